// ----- hdl/scm_pkg.sv -----
`default_nettype none

package scm_pkg;

    // position width, fixed by the sample format
    localparam int unsigned POS_BITS = 24;

    // command codes
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_STOP  = 3'd1;
    localparam logic [2:0] CMD_RIGHT = 3'd2;
    localparam logic [2:0] CMD_LEFT  = 3'd3;
    localparam logic [2:0] CMD_FWD   = 3'd4;

    // phase codes
    localparam logic [1:0] PH_NONE  = 2'd0;
    localparam logic [1:0] PH_RIGHT = 2'd1;
    localparam logic [1:0] PH_FWD   = 2'd2;
    localparam logic [1:0] PH_LEFT  = 2'd3;

    // register indexes
    localparam logic [1:0] REG_FWD_LEG   = 2'd0;
    localparam logic [1:0] REG_SIDE_LEG  = 2'd1;
    localparam logic [1:0] REG_STEER     = 2'd2;

    // register reset values
    localparam logic [15:0] FWD_LEG_RST  = 16'd500;
    localparam logic [15:0] SIDE_LEG_RST = 16'd10000;

    // input beat
    typedef struct packed {
        logic signed [POS_BITS-1:0] pos_x_mm;
        logic signed [POS_BITS-1:0] pos_y_mm;
        logic                       right_free;
        logic                       left_free;
        logic                       front_free;
    } t_scm_in;

    // result beat
    typedef struct packed {
        logic [2:0] command;
        logic [1:0] phase_now;
    } t_scm_out;

endpackage

`default_nettype wire

// ----- hdl/sweep_coverage_motion_fsm.sv -----
// an accepted input beat is held in the input register, its result in the result register
// throughput: one beat per cycle unless the output stalls; the input register feeds
// the distance test and phase update, which load the result register and the sweep state together
// reset: synchronous active low; leg limits return to 500 mm and 10000 mm, phase to
// right, and the first beat after reset latches the leg start point
`default_nettype none

module sweep_coverage_motion_fsm
    import scm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_scm_in     i_in_data,

    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_scm_out         o_out_data,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // configuration registers
    logic [15:0] r_fwd_leg;
    logic [15:0] r_side_leg;
    logic        r_steer;

    // pipeline registers
    logic        r_in_valid;
    t_scm_in     r_in;
    logic        r_out_valid;
    t_scm_out    r_out;

    // sweep state
    logic [1:0]                 r_phase, n_phase;
    logic [1:0]                 r_prev, n_prev;
    logic [1:0]                 r_last, n_last;
    logic signed [POS_BITS-1:0] r_sx, n_sx;
    logic signed [POS_BITS-1:0] r_sy, n_sy;
    logic                       r_side, n_side;
    logic                       r_started;

    logic        out_ready;
    logic        proc;
    logic        in_ready;
    logic        cfg_wr;
    logic [2:0]  cmd;

    // distance test signals
    logic signed [POS_BITS-1:0] eff_sx, eff_sy;
    logic                       eff_side;
    logic signed [POS_BITS:0]   dx, dy;
    logic [POS_BITS:0]          ax, ay;
    logic                       big;
    logic [31:0]                sq_x, sq_y, lim_sq;
    logic [32:0]                sum_sq;
    logic [15:0]                lim;
    logic                       done;
    logic                       side_go;
    logic                       side_upd;

    // handshake
    assign out_ready  = !r_out_valid || !i_out_stall;
    assign proc       = r_in_valid && out_ready;
    assign in_ready   = !r_in_valid || out_ready;
    assign o_in_stall = !in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[3:2])
            REG_FWD_LEG:  prdata = {16'd0, r_fwd_leg};
            REG_SIDE_LEG: prdata = {16'd0, r_side_leg};
            REG_STEER:    prdata = {31'd0, r_steer};
            default:      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_leg  <= FWD_LEG_RST;
            r_side_leg <= SIDE_LEG_RST;
            r_steer    <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_FWD_LEG:  r_fwd_leg  <= pwdata[15:0];
                REG_SIDE_LEG: r_side_leg <= pwdata[15:0];
                REG_STEER:    r_steer    <= pwdata[0];
                default:      ;
            endcase
        end
    end

    // leg start, the first beat takes the sample itself
    assign eff_sx   = r_started ? r_sx : r_in.pos_x_mm;
    assign eff_sy   = r_started ? r_sy : r_in.pos_y_mm;
    assign eff_side = r_started ? r_side : 1'b0;

    // squared distance against squared limit
    assign dx  = {r_in.pos_x_mm[POS_BITS-1], r_in.pos_x_mm} - {eff_sx[POS_BITS-1], eff_sx};
    assign dy  = {r_in.pos_y_mm[POS_BITS-1], r_in.pos_y_mm} - {eff_sy[POS_BITS-1], eff_sy};
    assign ax  = dx[POS_BITS] ? (~dx + 1'b1) : dx;
    assign ay  = dy[POS_BITS] ? (~dy + 1'b1) : dy;
    assign big = (|ax[POS_BITS:16]) || (|ay[POS_BITS:16]);
    assign sq_x   = ax[15:0] * ax[15:0];
    assign sq_y   = ay[15:0] * ay[15:0];
    assign sum_sq = {1'b0, sq_x} + {1'b0, sq_y};
    assign lim    = eff_side ? r_side_leg : r_fwd_leg;
    assign lim_sq = lim * lim;
    assign done   = big || (sum_sq > {1'b0, lim_sq});

    // sideways command once per leg or on every beat
    assign side_go  = !r_steer || (r_last != r_phase);
    assign side_upd = r_steer && (r_last != r_phase);

    // phase update
    always_comb begin
        cmd     = CMD_NONE;
        n_phase = r_phase;
        n_prev  = r_prev;
        n_last  = r_last;
        n_sx    = eff_sx;
        n_sy    = eff_sy;
        n_side  = eff_side;
        case (r_phase)
            PH_RIGHT: begin
                if (r_prev != PH_LEFT) begin
                    if (!r_in.right_free || done) begin
                        cmd    = CMD_STOP;
                        n_sx   = r_in.pos_x_mm;
                        n_sy   = r_in.pos_y_mm;
                        n_prev = PH_RIGHT;
                        if (!r_in.front_free) begin
                            n_phase = PH_LEFT;
                            n_side  = 1'b1;
                        end else begin
                            n_phase = PH_FWD;
                            n_side  = 1'b0;
                        end
                    end else begin
                        cmd = side_go ? CMD_RIGHT : CMD_NONE;
                        if (side_upd) n_last = r_phase;
                    end
                end else begin
                    if (r_in.front_free || !r_in.right_free || done) begin
                        cmd     = CMD_STOP;
                        n_sx    = r_in.pos_x_mm;
                        n_sy    = r_in.pos_y_mm;
                        n_phase = PH_FWD;
                        n_prev  = PH_LEFT;
                        n_side  = 1'b0;
                    end else begin
                        cmd = side_go ? CMD_RIGHT : CMD_NONE;
                        if (side_upd) n_last = r_phase;
                    end
                end
            end
            PH_FWD: begin
                if (r_prev == PH_RIGHT || r_prev == PH_LEFT) begin
                    if (done || !r_in.front_free) begin
                        cmd     = CMD_STOP;
                        n_sx    = r_in.pos_x_mm;
                        n_sy    = r_in.pos_y_mm;
                        n_phase = (r_prev == PH_RIGHT) ? PH_LEFT : PH_RIGHT;
                        n_prev  = PH_FWD;
                        n_side  = 1'b1;
                    end else if (r_last != PH_FWD) begin
                        cmd    = CMD_FWD;
                        n_last = PH_FWD;
                    end
                end else begin
                    cmd = CMD_STOP;
                end
            end
            PH_LEFT: begin
                if (r_prev != PH_RIGHT) begin
                    if (!r_in.left_free || done) begin
                        cmd    = CMD_STOP;
                        n_sx   = r_in.pos_x_mm;
                        n_sy   = r_in.pos_y_mm;
                        n_prev = PH_LEFT;
                        if (!r_in.front_free) begin
                            n_phase = PH_RIGHT;
                            n_side  = 1'b1;
                        end else begin
                            n_phase = PH_FWD;
                            n_side  = 1'b0;
                        end
                    end else begin
                        cmd = side_go ? CMD_LEFT : CMD_NONE;
                        if (side_upd) n_last = r_phase;
                    end
                end else begin
                    if (r_in.front_free || !r_in.left_free || done) begin
                        cmd     = CMD_STOP;
                        n_sx    = r_in.pos_x_mm;
                        n_sy    = r_in.pos_y_mm;
                        n_phase = PH_FWD;
                        n_prev  = PH_RIGHT;
                        n_side  = 1'b0;
                    end else begin
                        cmd = side_go ? CMD_LEFT : CMD_NONE;
                        if (side_upd) n_last = r_phase;
                    end
                end
            end
            default: begin
                cmd = CMD_NONE;
            end
        endcase
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= proc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_out.command   <= cmd;
            r_out.phase_now <= n_phase;
        end
    end

    // sweep state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_RIGHT;
            r_prev    <= PH_FWD;
            r_last    <= PH_NONE;
            r_sx      <= '0;
            r_sy      <= '0;
            r_side    <= 1'b0;
            r_started <= 1'b0;
        end else if (proc) begin
            r_phase   <= n_phase;
            r_prev    <= n_prev;
            r_last    <= n_last;
            r_sx      <= n_sx;
            r_sy      <= n_sy;
            r_side    <= n_side;
            r_started <= 1'b1;
        end
    end

endmodule

`default_nettype wire
